// ===== hw/rtl/bitmap_block_allocator_top_defines.svh =====
// assertion macros used by the bitmap block allocator checker
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while the active-low reset is low
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while the active-low reset is low
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bba_pkg.sv =====
// types and constants of the bitmap block allocator
`default_nettype none

package bba_pkg;

    localparam int CNT_W     = 17;
    localparam int BLK_W     = 16;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] TOTAL_RESET    = 17'h10000;
    localparam logic [CNT_W-1:0] RESERVED_RESET = 17'h00000;

    typedef enum logic [OP_W-1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL    = 1'b0,
        CFG_RESERVED = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_FILL  = 2'd0,
        S_IDLE  = 2'd1,
        S_ALLOC = 2'd2,
        S_RMW   = 2'd3
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BLK_W-1:0] block;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [BLK_W-1:0] block_out;
        logic             used_bit;
        logic [CNT_W-1:0] free_count;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_word_unit.sv =====
// shared word unit: range mask of a map word and lowest free bit search
`default_nettype none

module bba_word_unit #(
    parameter int WORD_BITS = 32,
    parameter int AW        = 11,
    parameter int IDX_W     = 17,
    localparam int BW       = $clog2(WORD_BITS)
) (
    input  wire logic [IDX_W-1:0]     i_limit,
    input  wire logic [AW-1:0]        i_word,
    input  wire logic [WORD_BITS-1:0] i_data,
    output logic      [WORD_BITS-1:0] o_mask,
    output logic      [WORD_BITS-1:0] o_onehot,
    output logic                      o_found,
    output logic      [BW-1:0]        o_bit_idx
);

    logic [IDX_W-1:0]     base;
    logic [IDX_W-1:0]     diff;
    logic [WORD_BITS-1:0] free_bits;

    // bits of this word whose block number lies below the limit
    always_comb begin
        base = IDX_W'(i_word) << BW;
        diff = i_limit - base;
        if (i_limit <= base) begin
            o_mask = '0;
        end else if (diff >= IDX_W'(WORD_BITS)) begin
            o_mask = '1;
        end else begin
            o_mask = ~({WORD_BITS{1'b1}} << diff[BW-1:0]);
        end
    end

    // lowest clear bit in range
    always_comb begin
        free_bits = ~i_data & o_mask;
        o_onehot  = free_bits & (~free_bits + WORD_BITS'(1));
        o_found   = |free_bits;
        o_bit_idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (o_onehot[j]) begin
                o_bit_idx = o_bit_idx | BW'(j);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator_top.sv =====
// bitmap block allocator: first-fit used map with free count
//
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+--------------------------
// command   | in        | start high, busy low    | i_cmd (op, block)
// result    | out       | o_done, one cycle       | o_result (status, block_out,
//           |           |                         |   used_bit, free_count)
// config    | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// free and read issue the registered map read on accept, then finish in S_RMW
// allocate scans one map word per cycle from word 0, up to the word of the last block
// format writes every map word once
// after reset a clearing pass over every map word runs with busy high
// results are registered and show in the cycle after the last work cycle; the receiver cannot stall
`default_nettype none

module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 65536,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire t_cmd                 i_cmd,
    output logic                      busy,
    output logic                      o_done,
    output t_result                   o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CNT_W-1:0]     i_cfg_data
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = (AW + BW + 1 > CNT_W) ? AW + BW + 1 : CNT_W;
    localparam logic [CNT_W-1:0] MAX_CLIP =
        (MAX_BLOCKS > (2 ** CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(MAX_BLOCKS);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_total, r_reserved;
    logic [CNT_W-1:0]     r_free, n_free;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic                 r_report, n_report;
    logic [AW-1:0]        r_word, n_word;
    logic [BLK_W-1:0]     r_blk, n_blk;
    logic                 r_is_free, n_is_free;
    logic                 r_done, n_done;
    t_result              r_res, n_res;

    logic [CNT_W-1:0]     eff_tot;
    logic [CNT_W-1:0]     res_clip;
    logic [IDX_W-1:0]     tot_x;
    logic [IDX_W-1:0]     blk_x;
    logic [IDX_W-1:0]     rblk_x;
    logic [IDX_W-1:0]     next_base;
    logic [IDX_W-1:0]     alloc_n;
    logic                 accept;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [IDX_W-1:0]     wu_limit;
    logic [WORD_BITS-1:0] wu_mask;
    logic [WORD_BITS-1:0] wu_onehot;
    logic                 wu_found;
    logic [BW-1:0]        wu_bit_idx;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && (r_state == S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    always_comb begin
        eff_tot   = (r_total > MAX_CLIP) ? MAX_CLIP : r_total;
        res_clip  = (r_reserved > eff_tot) ? eff_tot : r_reserved;
        tot_x     = IDX_W'(eff_tot);
        blk_x     = IDX_W'(i_cmd.block);
        rblk_x    = IDX_W'(r_blk);
        next_base = (IDX_W'(r_word) + IDX_W'(1)) << BW;
        alloc_n   = (IDX_W'(r_word) << BW) | IDX_W'(wu_bit_idx);
        wu_limit  = (r_state == S_FILL) ? IDX_W'(r_fill) : tot_x;
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_word_unit #(
        .WORD_BITS (WORD_BITS),
        .AW        (AW),
        .IDX_W     (IDX_W)
    ) u_word (
        .i_limit   (wu_limit),
        .i_word    (r_word),
        .i_data    (ram_rdata),
        .o_mask    (wu_mask),
        .o_onehot  (wu_onehot),
        .o_found   (wu_found),
        .o_bit_idx (wu_bit_idx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL: begin
                if (r_word == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_cmd.op))
                        OP_FORMAT: n_state = S_FILL;
                        OP_ALLOC: begin
                            if (r_free != '0 && eff_tot != '0) begin
                                n_state = S_ALLOC;
                            end
                        end
                        default: begin
                            if (blk_x < tot_x) begin
                                n_state = S_RMW;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (wu_found || next_base >= tot_x) begin
                    n_state = S_IDLE;
                end
            end
            S_RMW: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, map port and result
    always_comb begin
        n_free    = r_free;
        n_fill    = r_fill;
        n_report  = r_report;
        n_word    = r_word;
        n_blk     = r_blk;
        n_is_free = r_is_free;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = wu_mask;
        ram_raddr = '0;
        case (r_state)
            S_FILL: begin
                ram_we = 1'b1;
                n_word = r_word + AW'(1);
                if (r_word == LAST_WORD) begin
                    n_word = '0;
                    if (r_report) begin
                        n_free           = eff_tot - r_fill;
                        n_done           = 1'b1;
                        n_res.status     = ST_OK;
                        n_res.block_out  = '0;
                        n_res.used_bit   = 1'b0;
                        n_res.free_count = eff_tot - r_fill;
                    end
                end
            end
            S_IDLE: begin
                ram_raddr = (t_op'(i_cmd.op) == OP_ALLOC) ? '0 : blk_x[BW +: AW];
                if (accept) begin
                    n_res.block_out  = '0;
                    n_res.used_bit   = 1'b0;
                    n_res.free_count = r_free;
                    n_word           = '0;
                    n_blk            = i_cmd.block;
                    n_is_free        = (t_op'(i_cmd.op) == OP_FREE);
                    case (t_op'(i_cmd.op))
                        OP_FORMAT: begin
                            n_fill   = res_clip;
                            n_report = 1'b1;
                        end
                        OP_ALLOC: begin
                            if (r_free == '0 || eff_tot == '0) begin
                                n_done       = 1'b1;
                                n_res.status = ST_NO_FREE;
                            end
                        end
                        default: begin
                            if (blk_x >= tot_x) begin
                                n_done       = 1'b1;
                                n_res.status = ST_RANGE;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                ram_raddr = r_word + AW'(1);
                ram_wdata = ram_rdata | wu_onehot;
                if (wu_found) begin
                    ram_we           = 1'b1;
                    n_free           = r_free - CNT_W'(1);
                    n_done           = 1'b1;
                    n_res.status     = ST_OK;
                    n_res.block_out  = alloc_n[BLK_W-1:0];
                    n_res.free_count = r_free - CNT_W'(1);
                end else if (next_base >= tot_x) begin
                    n_done       = 1'b1;
                    n_res.status = ST_NO_FREE;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            S_RMW: begin
                ram_waddr    = rblk_x[BW +: AW];
                ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << rblk_x[BW-1:0]);
                n_done       = 1'b1;
                n_res.status = ST_OK;
                if (r_is_free) begin
                    ram_we           = 1'b1;
                    n_free           = (r_free < eff_tot) ? r_free + CNT_W'(1) : eff_tot;
                    n_res.block_out  = r_blk;
                    n_res.free_count = (r_free < eff_tot) ? r_free + CNT_W'(1) : eff_tot;
                end else begin
                    n_res.used_bit = ram_rdata[rblk_x[BW-1:0]];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_total    <= TOTAL_RESET;
            r_reserved <= RESERVED_RESET;
            r_free     <= '0;
            r_fill     <= '0;
            r_report   <= 1'b0;
            r_word     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_fill   <= n_fill;
            r_report <= n_report;
            r_word   <= n_word;
            r_done   <= n_done;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TOTAL:    r_total    <= i_cfg_data;
                    CFG_RESERVED: r_reserved <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk     <= n_blk;
        r_is_free <= n_is_free;
        r_res     <= n_res;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_checker.sv =====
// port checker of the bitmap block allocator, bound to the top level
`default_nettype none
`include "bitmap_block_allocator_top_defines.svh"

module bba_checker
    import bba_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_done,
    input wire t_result              o_result
);

    // an accepted transaction either works on or answers at once
    `BBA_ASSERT_NXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted transaction neither busy nor answered")

    // a result only shows once the sequencer is back to idle
    `BBA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")

    // range errors carry no block and no bit
    `BBA_ASSERT_IMP(a_range_clean, i_clk, i_rst_n, o_done && o_result.status == ST_RANGE, o_result.block_out == '0 && !o_result.used_bit, "range error with payload")

    // every result follows work or a command
    `BBA_ASSERT_IMP(a_done_cause, i_clk, i_rst_n, o_done, $past(busy) || $past(start), "result without transaction")

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);

`default_nettype wire
